[rtl/jt_pkg.sv]
// Shared types and constants of the JSON tokenizer.
// Used by the controller, the datapath and the top level; depends on nothing.
package jt_pkg;

  localparam int IDX_W  = 6;
  localparam int POS_OW = 17;
  localparam int CNT_W  = 7;
  localparam int ST_W   = 3;

  localparam logic [CNT_W-1:0] NO_PARENT = 7'h7F;

  localparam logic [1:0] KIND_OBJ  = 2'd0;
  localparam logic [1:0] KIND_ARR  = 2'd1;
  localparam logic [1:0] KIND_STR  = 2'd2;
  localparam logic [1:0] KIND_PRIM = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd1;
  localparam logic [ST_W-1:0] ST_INVAL = 3'd2;
  localparam logic [ST_W-1:0] ST_PART  = 3'd3;
  localparam logic [ST_W-1:0] ST_LONG  = 3'd4;

  localparam logic [0:0] REG_STRICT = 1'b0;
  localparam logic [0:0] REG_COUNT  = 1'b1;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_STR    = 3'd1,
    MODE_ESC    = 3'd2,
    MODE_HEX    = 3'd3,
    MODE_PRIM   = 3'd4
  } mode_t;

  // one strobe per controller state
  typedef struct packed {
    logic idle;
    logic exec;
    logic redo;
    logic stk;
    logic fetch;
    logic load;
    logic fin;
    logic wb;
    logic stat;
    logic rd;
    logic cap;
    logic send;
  } cmd_t;

  typedef struct packed {
    logic redo;
    logic pop;
    logic fetch;
    logic last;
    logic stk_some;
    logic dump;
    logic sent;
    logic sent_last;
  } sts_t;

endpackage

[rtl/jt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module jt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/jt_ctrl.sv]
// Sequencing state machine of the JSON tokenizer.
// Depends on jt_pkg; drives the datapath through cmd_t and reads sts_t.
module jt_ctrl
  import jt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  sts_t st,
  output cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_EXEC  = 12'b000000000010,
    S_REDO  = 12'b000000000100,
    S_STK   = 12'b000000001000,
    S_FETCH = 12'b000000010000,
    S_LOAD  = 12'b000000100000,
    S_FIN   = 12'b000001000000,
    S_WB    = 12'b000010000000,
    S_STAT  = 12'b000100000000,
    S_RD    = 12'b001000000000,
    S_CAP   = 12'b010000000000,
    S_SEND  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  state_t after_byte;

  always_comb begin
    after_byte = st.last ? S_FIN : S_IDLE;
    state_nxt  = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_EXEC;
      S_EXEC, S_REDO: begin
        if (st.redo)       state_nxt = S_REDO;
        else if (st.pop)   state_nxt = S_STK;
        else if (st.fetch) state_nxt = S_FETCH;
        else               state_nxt = after_byte;
      end
      S_STK:   state_nxt = st.stk_some ? S_FETCH : after_byte;
      S_FETCH: state_nxt = S_LOAD;
      S_LOAD:  state_nxt = after_byte;
      S_FIN:   state_nxt = S_WB;
      // status decided by the write-back cycle is visible here
      S_WB:    state_nxt = S_STAT;
      S_STAT:  state_nxt = st.dump ? S_RD : S_CAP;
      S_RD:    state_nxt = S_CAP;
      S_CAP:   state_nxt = S_SEND;
      S_SEND: begin
        if (st.sent) state_nxt = st.sent_last ? S_IDLE : S_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.idle  = (state_r == S_IDLE);
  assign cmd.exec  = (state_r == S_EXEC);
  assign cmd.redo  = (state_r == S_REDO);
  assign cmd.stk   = (state_r == S_STK);
  assign cmd.fetch = (state_r == S_FETCH);
  assign cmd.load  = (state_r == S_LOAD);
  assign cmd.fin   = (state_r == S_FIN);
  assign cmd.wb    = (state_r == S_WB);
  assign cmd.stat  = (state_r == S_STAT) && !st.dump;
  assign cmd.rd    = (state_r == S_RD);
  assign cmd.cap   = (state_r == S_CAP);
  assign cmd.send  = (state_r == S_SEND);

endmodule

[rtl/jt_dp.sv]
// Datapath of the JSON tokenizer: scan state, token tables, container stack
// and output register. Depends on jt_pkg and jt_ram; commanded by jt_ctrl.
module jt_dp
  import jt_pkg::*;
#(
  parameter int MAX_TOKENS = 64,
  parameter int MAX_TEXT   = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              strict_mode,
  input  logic              count_only,
  input  cmd_t              cmd,
  output sts_t              st,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [IDX_W-1:0]  o_index,
  output logic [1:0]        o_kind,
  output logic [POS_OW-1:0] o_begin,
  output logic [POS_OW-1:0] o_finish,
  output logic [CNT_W-1:0]  o_children,
  output logic              o_has,
  output logic [ST_W-1:0]   o_status,
  output logic [POS_OW-1:0] o_total,
  output logic              o_last
);

  localparam int AW    = $clog2(MAX_TOKENS);
  localparam int PW0   = $clog2(MAX_TEXT + 1);
  localparam int POS_W = (PW0 > POS_OW) ? PW0 : POS_OW;
  localparam int SW    = AW + 1;

  localparam logic [CNT_W-1:0] TOK_LIMIT = CNT_W'(MAX_TOKENS);
  localparam logic [POS_W-1:0] TEXT_LIMIT = POS_W'(MAX_TEXT);

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_D0     = 8'd48;
  localparam logic [7:0] CH_D9     = 8'd57;
  localparam logic [7:0] CH_UA     = 8'd65;
  localparam logic [7:0] CH_UF     = 8'd70;
  localparam logic [7:0] CH_LA     = 8'd97;
  localparam logic [7:0] CH_LF_HEX = 8'd102;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= CH_D0 && c <= CH_D9) || (c >= CH_UA && c <= CH_UF) ||
           (c >= CH_LA && c <= CH_LF_HEX);
  endfunction

  function automatic logic is_delim(input logic [7:0] c, input logic strict);
    return c == CH_TAB || c == CH_CR || c == CH_LF || c == CH_SPACE ||
           c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE ||
           (c == CH_COLON && !strict);
  endfunction

  // control state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  nfree_r, nfree_nxt;
  logic [CNT_W-1:0]  parent_r, parent_nxt;
  logic [POS_OW-1:0] total_r, total_nxt;
  mode_t             mode_r, mode_nxt;
  logic [2:0]        hex_r, hex_nxt;
  logic [ST_W-1:0]   err_r, err_nxt;
  logic              ended_r, ended_nxt;
  logic [CNT_W-1:0]  sp_r, sp_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              ovalid_r, ovalid_nxt;
  // payload
  logic [POS_OW-1:0] ibeg_r, ibeg_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic [AW-1:0]     top_idx_r, top_idx_nxt;
  logic              top_arr_r, top_arr_nxt;
  logic [1:0]        pkind_r, pkind_nxt;
  logic [CNT_W-1:0]  pchild_r, pchild_nxt;
  logic [IDX_W-1:0]  oidx_r, oidx_nxt;
  logic [1:0]        okind_r, okind_nxt;
  logic [POS_OW-1:0] obeg_r, obeg_nxt;
  logic [POS_OW-1:0] ofin_r, ofin_nxt;
  logic [CNT_W-1:0]  ochild_r, ochild_nxt;
  logic              ohas_r, ohas_nxt;
  logic [ST_W-1:0]   ostat_r, ostat_nxt;
  logic [POS_OW-1:0] otot_r, otot_nxt;
  logic              olast_r, olast_nxt;

  // table ports
  logic              kind_we, beg_we, fin_we, ch_we, stk_we;
  logic [AW-1:0]     t_waddr, ch_waddr, stk_waddr, t_raddr, stk_raddr;
  logic [1:0]        kind_wd, kind_rd;
  logic [POS_OW-1:0] beg_wd, beg_rd, fin_wd, fin_rd;
  logic [CNT_W-1:0]  ch_wd, ch_rd;
  logic [SW-1:0]     stk_wd, stk_rd;

  jt_ram #(.WIDTH(2), .DEPTH(MAX_TOKENS)) u_kind (
    .clk(clk), .we(kind_we), .waddr(t_waddr), .wdata(kind_wd),
    .raddr(t_raddr), .rdata(kind_rd));
  jt_ram #(.WIDTH(POS_OW), .DEPTH(MAX_TOKENS)) u_beg (
    .clk(clk), .we(beg_we), .waddr(t_waddr), .wdata(beg_wd),
    .raddr(t_raddr), .rdata(beg_rd));
  jt_ram #(.WIDTH(POS_OW), .DEPTH(MAX_TOKENS)) u_fin (
    .clk(clk), .we(fin_we), .waddr(t_waddr), .wdata(fin_wd),
    .raddr(t_raddr), .rdata(fin_rd));
  jt_ram #(.WIDTH(CNT_W), .DEPTH(MAX_TOKENS)) u_child (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wd),
    .raddr(t_raddr), .rdata(ch_rd));
  jt_ram #(.WIDTH(SW), .DEPTH(MAX_TOKENS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wd),
    .raddr(stk_raddr), .rdata(stk_rd));

  logic              do_leaf, do_norm, do_end, full, has_par, err_ok;
  logic [1:0]        leaf_kind;
  logic [POS_OW-1:0] leaf_beg, leaf_end;
  logic [POS_W-1:0]  pos_use;
  logic [CNT_W-1:0]  new_par;
  logic [7:0]        c;
  logic              want_arr;

  always_comb begin
    pos_nxt = pos_r; nfree_nxt = nfree_r; parent_nxt = parent_r;
    total_nxt = total_r; mode_nxt = mode_r; hex_nxt = hex_r; err_nxt = err_r;
    ended_nxt = ended_r; sp_nxt = sp_r; k_nxt = k_r; ovalid_nxt = ovalid_r;
    ibeg_nxt = ibeg_r; byte_nxt = byte_r; last_nxt = last_r;
    top_idx_nxt = top_idx_r; top_arr_nxt = top_arr_r;
    pkind_nxt = pkind_r; pchild_nxt = pchild_r;
    oidx_nxt = oidx_r; okind_nxt = okind_r; obeg_nxt = obeg_r; ofin_nxt = ofin_r;
    ochild_nxt = ochild_r; ohas_nxt = ohas_r; ostat_nxt = ostat_r;
    otot_nxt = otot_r; olast_nxt = olast_r;
    kind_we = 1'b0; beg_we = 1'b0; fin_we = 1'b0; ch_we = 1'b0; stk_we = 1'b0;
    t_waddr = nfree_r[AW-1:0]; ch_waddr = nfree_r[AW-1:0];
    stk_waddr = sp_r[AW-1:0];
    kind_wd = KIND_OBJ; beg_wd = '0; fin_wd = '0; ch_wd = '0; stk_wd = '0;
    t_raddr = cmd.fetch ? parent_r[AW-1:0] : k_r[AW-1:0];
    stk_raddr = AW'(sp_r - CNT_W'(2));
    st = '0;
    do_leaf = 1'b0; do_norm = 1'b0; do_end = 1'b0;
    leaf_kind = KIND_PRIM; leaf_beg = ibeg_r; leaf_end = pos_r[POS_OW-1:0];
    c = byte_r;
    err_ok = (err_r == ST_OK);
    full = (nfree_r >= TOK_LIMIT);
    has_par = (parent_r != NO_PARENT);
    pos_use = cmd.redo ? (pos_r - POS_W'(1)) : pos_r;
    new_par = (nfree_r == '0) ? NO_PARENT : (nfree_r - CNT_W'(1));
    want_arr = (c == CH_RBRACK);

    if (in_fire) begin
      byte_nxt = in_byte;
      last_nxt = in_last;
    end

    if (cmd.exec && err_ok && !ended_r) begin
      if (pos_r >= TEXT_LIMIT) begin
        err_nxt = ST_LONG;
      end else if (c == CH_NUL) begin
        do_end = 1'b1;
        ended_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        case (mode_r)
          MODE_STR: begin
            if (c == CH_QUOTE) begin
              mode_nxt = MODE_NORMAL;
              do_leaf = 1'b1;
              leaf_kind = KIND_STR;
              leaf_beg = ibeg_r + POS_OW'(1);
            end else if (c == CH_BSLASH) begin
              mode_nxt = MODE_ESC;
            end
          end
          MODE_ESC: begin
            if (c == CH_QUOTE || c == CH_SLASH || c == CH_BSLASH || c == CH_B ||
                c == CH_LF_HEX || c == CH_R || c == CH_N || c == CH_T) begin
              mode_nxt = MODE_STR;
            end else if (c == CH_U) begin
              mode_nxt = MODE_HEX;
              hex_nxt = 3'd4;
            end else begin
              err_nxt = ST_INVAL;
            end
          end
          MODE_HEX: begin
            if (!is_hex(c)) begin
              err_nxt = ST_INVAL;
            end else begin
              hex_nxt = hex_r - 3'd1;
              if (hex_r == 3'd1) mode_nxt = MODE_STR;
            end
          end
          MODE_PRIM: begin
            if (is_delim(c, strict_mode)) begin
              // close the primitive now, treat the delimiter on the next pass
              mode_nxt = MODE_NORMAL;
              do_leaf = 1'b1;
              st.redo = 1'b1;
            end else if (c < CH_SPACE || c >= CH_DEL) begin
              err_nxt = ST_INVAL;
            end
          end
          default: begin
            mode_nxt = MODE_NORMAL;
            do_norm = 1'b1;
          end
        endcase
      end
    end

    if (cmd.redo) do_norm = err_ok;
    if (cmd.fin)  do_end = !ended_r;

    if (do_end && err_ok) begin
      if (mode_r == MODE_PRIM) begin
        if (strict_mode) err_nxt = ST_PART;
        else do_leaf = 1'b1;
      end else if (mode_r != MODE_NORMAL) begin
        err_nxt = ST_PART;
      end
      mode_nxt = MODE_NORMAL;
    end

    if (do_leaf) begin
      if (count_only) begin
        total_nxt = total_r + POS_OW'(1);
      end else if (full) begin
        err_nxt = ST_FULL;
      end else begin
        kind_we = 1'b1; beg_we = 1'b1; fin_we = 1'b1; ch_we = 1'b1;
        kind_wd = leaf_kind; beg_wd = leaf_beg; fin_wd = leaf_end; ch_wd = '0;
        nfree_nxt = nfree_r + CNT_W'(1);
        total_nxt = total_r + POS_OW'(1);
        if (has_par) pchild_nxt = pchild_r + CNT_W'(1);
      end
    end

    if (do_norm) begin
      case (c)
        CH_LBRACE, CH_LBRACK: begin
          total_nxt = total_r + POS_OW'(1);
          if (!count_only) begin
            if (full) begin
              err_nxt = ST_FULL;
            end else begin
              if (has_par) begin
                ch_we = 1'b1;
                ch_waddr = parent_r[AW-1:0];
                ch_wd = pchild_r + CNT_W'(1);
              end
              kind_we = 1'b1; beg_we = 1'b1; fin_we = 1'b1;
              kind_wd = (c == CH_LBRACE) ? KIND_OBJ : KIND_ARR;
              beg_wd = pos_use[POS_OW-1:0];
              fin_wd = '0;
              stk_we = 1'b1;
              stk_wd = {c == CH_LBRACK, nfree_r[AW-1:0]};
              sp_nxt = sp_r + CNT_W'(1);
              top_idx_nxt = nfree_r[AW-1:0];
              top_arr_nxt = (c == CH_LBRACK);
              parent_nxt = nfree_r;
              pkind_nxt = kind_wd;
              pchild_nxt = '0;
              nfree_nxt = nfree_r + CNT_W'(1);
            end
          end
        end
        CH_RBRACE, CH_RBRACK: begin
          if (!count_only) begin
            if (sp_r == '0 || top_arr_r != want_arr) begin
              err_nxt = ST_INVAL;
            end else begin
              fin_we = 1'b1;
              t_waddr = top_idx_r;
              fin_wd = pos_use[POS_OW-1:0] + POS_OW'(1);
              sp_nxt = sp_r - CNT_W'(1);
              if (has_par) begin
                ch_we = 1'b1;
                ch_waddr = parent_r[AW-1:0];
                ch_wd = pchild_r;
              end
              st.pop = 1'b1;
            end
          end
        end
        CH_QUOTE: begin
          ibeg_nxt = pos_use[POS_OW-1:0];
          mode_nxt = MODE_STR;
        end
        CH_TAB, CH_CR, CH_LF, CH_SPACE: ;
        CH_COLON: begin
          if (has_par) begin
            ch_we = 1'b1;
            ch_waddr = parent_r[AW-1:0];
            ch_wd = pchild_r;
          end
          parent_nxt = new_par;
          st.fetch = (new_par != NO_PARENT);
        end
        CH_COMMA: begin
          if (!count_only && has_par && pkind_r >= KIND_STR && sp_r != '0) begin
            ch_we = 1'b1;
            ch_waddr = parent_r[AW-1:0];
            ch_wd = pchild_r;
            parent_nxt = CNT_W'(top_idx_r);
            st.fetch = 1'b1;
          end
        end
        default: begin
          if (strict_mode && !(c == CH_MINUS || (c >= CH_D0 && c <= CH_D9) ||
              c == CH_T || c == CH_LF_HEX || c == CH_N)) begin
            err_nxt = ST_INVAL;
          end else if (strict_mode && !count_only && has_par &&
                       (pkind_r == KIND_OBJ ||
                        (pkind_r == KIND_STR && pchild_r != '0))) begin
            err_nxt = ST_INVAL;
          end else if (c < CH_SPACE || c >= CH_DEL) begin
            err_nxt = ST_INVAL;
          end else begin
            ibeg_nxt = pos_use[POS_OW-1:0];
            mode_nxt = MODE_PRIM;
          end
        end
      endcase
    end

    // the container below the one just closed becomes the parent
    if (cmd.stk) begin
      if (sp_r != '0) begin
        parent_nxt = CNT_W'(stk_rd[AW-1:0]);
        top_idx_nxt = stk_rd[AW-1:0];
        top_arr_nxt = stk_rd[AW];
        st.stk_some = 1'b1;
      end else begin
        parent_nxt = NO_PARENT;
      end
    end

    if (cmd.load) begin
      pkind_nxt = kind_rd;
      pchild_nxt = ch_rd;
    end

    if (cmd.wb) begin
      if (has_par && !count_only) begin
        ch_we = 1'b1;
        ch_waddr = parent_r[AW-1:0];
        ch_wd = pchild_r;
      end
      if (err_ok && !count_only && sp_r != '0) err_nxt = ST_PART;
    end

    st.dump = err_ok && !count_only && nfree_r != '0;

    if (cmd.stat) begin
      oidx_nxt = '0; okind_nxt = KIND_OBJ; obeg_nxt = '0; ofin_nxt = '0;
      ochild_nxt = '0; ohas_nxt = 1'b0; ostat_nxt = err_r;
      otot_nxt = err_ok ? total_r : '0;
      olast_nxt = 1'b1;
    end

    if (cmd.cap) begin
      ovalid_nxt = 1'b1;
      if (st.dump) begin
        oidx_nxt = IDX_W'(k_r);
        okind_nxt = kind_rd; obeg_nxt = beg_rd; ofin_nxt = fin_rd;
        ochild_nxt = ch_rd; ohas_nxt = 1'b1; ostat_nxt = ST_OK;
        otot_nxt = total_r;
        olast_nxt = (k_r + CNT_W'(1) == nfree_r);
      end
    end

    st.last = last_r;
    st.sent = cmd.send && ovalid_r && out_ready;
    st.sent_last = olast_r;

    if (st.sent) begin
      ovalid_nxt = 1'b0;
      if (olast_r) begin
        // run over: back to the state after reset
        pos_nxt = '0; nfree_nxt = '0; parent_nxt = NO_PARENT; total_nxt = '0;
        mode_nxt = MODE_NORMAL; hex_nxt = '0; ibeg_nxt = '0; err_nxt = ST_OK;
        ended_nxt = 1'b0; sp_nxt = '0; k_nxt = '0;
      end else begin
        k_nxt = k_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; nfree_r <= '0; parent_r <= NO_PARENT; total_r <= '0;
      mode_r <= MODE_NORMAL; hex_r <= '0; err_r <= ST_OK; ended_r <= 1'b0;
      sp_r <= '0; k_r <= '0; ovalid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt; nfree_r <= nfree_nxt; parent_r <= parent_nxt;
      total_r <= total_nxt; mode_r <= mode_nxt; hex_r <= hex_nxt;
      err_r <= err_nxt; ended_r <= ended_nxt; sp_r <= sp_nxt; k_r <= k_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ibeg_r <= ibeg_nxt; byte_r <= byte_nxt; last_r <= last_nxt;
    top_idx_r <= top_idx_nxt; top_arr_r <= top_arr_nxt;
    pkind_r <= pkind_nxt; pchild_r <= pchild_nxt;
    oidx_r <= oidx_nxt; okind_r <= okind_nxt; obeg_r <= obeg_nxt;
    ofin_r <= ofin_nxt; ochild_r <= ochild_nxt; ohas_r <= ohas_nxt;
    ostat_r <= ostat_nxt; otot_r <= otot_nxt; olast_r <= olast_nxt;
  end

  assign out_valid  = ovalid_r;
  assign o_index    = oidx_r;
  assign o_kind     = okind_r;
  assign o_begin    = obeg_r;
  assign o_finish   = ofin_r;
  assign o_children = ochild_r;
  assign o_has      = ohas_r;
  assign o_status   = ostat_r;
  assign o_total    = otot_r;
  assign o_last     = olast_r;

endmodule

[rtl/json_tokenizer.sv]
// JSON tokenizer top level: stream ports, configuration registers, assertions.
// Depends on jt_pkg, jt_ctrl and jt_dp.
//
// Usage: text enters on the in_ stream, one byte per word, in_tlast on the
// final byte. Tokens leave on the out_ stream after that final byte: one word
// per table entry in index order, or a single status word (has_token low) in
// count-only mode, on an error or for an empty table. out_tlast marks the
// final word of the run.
// Sequence: a byte is accepted when idle, then executed; a byte that ends a
// primitive adds a redo pass, a colon or comma that moves the current parent
// to a table entry adds fetch and load states to read that entry, and a
// closing bracket adds a stack read, plus fetch and load when an open
// container remains below it. After the final byte, the fin, write-back and
// status states settle the status; each result word is then captured and sent.
// in_tready is high only while the block is idle; no byte is taken while
// results are pending. A stalled receiver holds the current word.
// Reset (rst_n low, synchronous) clears the scan state and both registers;
// after the final word of a run the scan state returns to its reset value.
// Registers: 0x0 strict_mode, 0x4 count_only; write only while idle.
module json_tokenizer
  import jt_pkg::*;
#(
  parameter int MAX_TOKENS = 64,
  parameter int MAX_TEXT   = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // text_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // token_index[5:0] token_begin[22:6] token_finish[39:23] child_count[46:40]
  // parse_status[49:47] total_tokens[66:50] zero[71:67]
  output logic [71:0] out_tdata,
  output logic [2:0]  out_tuser,  // token_kind[1:0] has_token[2]
  output logic        out_tlast,  // last_result
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic strict_r, count_r;
  logic cfg_wr;
  cmd_t cmd;
  sts_t st;
  logic in_fire;

  logic [IDX_W-1:0]  o_index;
  logic [1:0]        o_kind;
  logic [POS_OW-1:0] o_begin, o_finish, o_total;
  logic [CNT_W-1:0]  o_children;
  logic              o_has, o_last;
  logic [ST_W-1:0]   o_status;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b0;
      count_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_STRICT: strict_r <= cfg_pwdata[0];
        REG_COUNT:  count_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_STRICT: cfg_prdata = {31'd0, strict_r};
      REG_COUNT:  cfg_prdata = {31'd0, count_r};
      default:    cfg_prdata = '0;
    endcase
  end

  assign in_tready = cmd.idle;
  assign in_fire   = in_tvalid && in_tready;

  jt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .st(st), .cmd(cmd));

  jt_dp #(.MAX_TOKENS(MAX_TOKENS), .MAX_TEXT(MAX_TEXT)) u_dp (
    .clk(clk), .rst_n(rst_n), .strict_mode(strict_r), .count_only(count_r),
    .cmd(cmd), .st(st), .in_fire(in_fire), .in_byte(in_tdata),
    .in_last(in_tlast), .out_ready(out_tready), .out_valid(out_tvalid),
    .o_index(o_index), .o_kind(o_kind), .o_begin(o_begin), .o_finish(o_finish),
    .o_children(o_children), .o_has(o_has), .o_status(o_status),
    .o_total(o_total), .o_last(o_last));

  assign out_tdata = {5'd0, o_total, o_status, o_children, o_finish, o_begin, o_index};
  assign out_tuser = {o_has, o_kind};
  assign out_tlast = o_last;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result word is pending");

  a_ready_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready)
    else $error("block not idle after the final word of a run");

  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tlast)
    else $error("status word not marked final");
`endif

endmodule
